>>> hdl/lkvc_pkg.sv
// Shared constants and types for the LRU key/value cache.
package lkvc_pkg;

    localparam int LKVC_DEPTH     = 16;
    localparam int LKVC_KEY_BITS  = 16;
    localparam int LKVC_KEY_W     = 16;
    localparam int LKVC_VALUE_W   = 32;
    localparam int LKVC_CAP_W     = 5;
    localparam logic [LKVC_CAP_W-1:0] LKVC_CAP_RESET = 5'd16;

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } t_cmd;

endpackage

>>> hdl/lru_key_value_cache.sv
// Top level of the LRU key/value cache: input register, entry state and result register.
// A transaction accepted at a clock edge is held in the input register, and its result is
// loaded into the result register once the stage fires, after any held result is taken.
// Throughput: one transaction per cycle while results drain, bounded by the combinational compare and rank update.
// Reset (synchronous, active low) empties the store and sets the capacity to sixteen entries;
// entry keys and values are not cleared and are only ever read through their valid bits.
module lru_key_value_cache #(
    parameter int DEPTH    = lkvc_pkg::LKVC_DEPTH,
    parameter int KEY_BITS = lkvc_pkg::LKVC_KEY_BITS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [lkvc_pkg::LKVC_CAP_W-1:0]         i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic                                    i_command,
    input  logic [lkvc_pkg::LKVC_KEY_W-1:0]         i_key,
    input  logic signed [lkvc_pkg::LKVC_VALUE_W-1:0] i_write_value,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic                                    o_hit,
    output logic signed [lkvc_pkg::LKVC_VALUE_W-1:0] o_read_value,
    output logic                                    o_evicted,
    output logic [lkvc_pkg::LKVC_KEY_W-1:0]         o_evicted_key
);

    import lkvc_pkg::*;

    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > LKVC_CAP_W) ? CW : LKVC_CAP_W;

    // Input register.
    logic                             r_in_valid;
    t_cmd                             r_cmd;
    logic [LKVC_KEY_W-1:0]            r_key;
    logic signed [LKVC_VALUE_W-1:0]   r_wval;

    // Entry state. Keys and values carry no reset; the valid bits gate every read.
    logic [DEPTH-1:0][KEY_BITS-1:0]   r_keys;
    logic signed [LKVC_VALUE_W-1:0]   r_vals [DEPTH];
    logic [DEPTH-1:0]                 r_valid;
    logic [DEPTH-1:0][RW-1:0]         r_rank;
    logic [CW-1:0]                    r_count;
    logic [LKVC_CAP_W-1:0]            r_cap;

    logic [DEPTH-1:0]                 n_valid;
    logic [DEPTH-1:0][RW-1:0]         n_rank;
    logic [CW-1:0]                    n_count;

    // Result register.
    logic                             r_out_valid;
    logic                             r_hit;
    logic signed [LKVC_VALUE_W-1:0]   r_rval;
    logic                             r_ev;
    logic [LKVC_KEY_W-1:0]            r_evkey;

    logic                             w_fire;
    logic [KEY_BITS-1:0]              w_key;
    logic                             w_hit;
    logic [IW-1:0]                    w_hit_idx;
    logic [RW-1:0]                    w_hit_rank;
    logic [CMPW-1:0]                  w_eff_cap;
    logic                             w_full;
    logic [RW-1:0]                    w_oldest;
    logic                             w_vic_evict;
    logic                             w_slot_ok;
    logic [IW-1:0]                    w_slot;
    logic                             w_miss_put;
    logic                             w_insert;
    logic                             w_evict;

    // The stage fires whenever a transaction sits in the input register and the result
    // register is empty or being drained, so back-to-back transactions stall only while a result waits.
    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    // Only the low KEY_BITS bits of the key take part.
    assign w_key = KEY_BITS'(r_key);

    lkvc_lookup #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS),
        .IW       (IW)
    ) u_lookup (
        .i_keys  (r_keys),
        .i_valid (r_valid),
        .i_key   (w_key),
        .o_hit   (w_hit),
        .o_index (w_hit_idx)
    );

    assign w_hit_rank = r_rank[w_hit_idx];

    // A capacity of zero acts as one and anything above the depth acts as the depth.
    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = CMPW'(1);
        end else if (CMPW'(r_cap) > CMPW'(DEPTH)) begin
            w_eff_cap = CMPW'(DEPTH);
        end else begin
            w_eff_cap = CMPW'(r_cap);
        end
    end

    assign w_full   = CMPW'(r_count) >= w_eff_cap;
    assign w_oldest = RW'(r_count - CW'(1));

    lkvc_victim #(
        .DEPTH (DEPTH),
        .IW    (IW),
        .RW    (RW)
    ) u_victim (
        .i_valid   (r_valid),
        .i_rank    (r_rank),
        .i_oldest  (w_oldest),
        .i_full    (w_full),
        .o_evict   (w_vic_evict),
        .o_slot_ok (w_slot_ok),
        .o_slot    (w_slot)
    );

    assign w_miss_put = (r_cmd == CMD_PUT) && !w_hit;
    assign w_insert   = w_miss_put && w_slot_ok;
    assign w_evict    = w_miss_put && w_vic_evict;

    // Recency update. A hit ages every entry that was newer than it and moves it to the
    // front. An insert ages every surviving entry and places the new one at the front; an
    // eviction reuses the victim slot, so the count stays the same.
    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        n_count = r_count;
        if (w_hit) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (r_valid[i] && (r_rank[i] < w_hit_rank)) begin
                    n_rank[i] = r_rank[i] + RW'(1);
                end
            end
            n_rank[w_hit_idx] = '0;
        end else if (w_insert) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (r_valid[i] && !(w_evict && (w_slot == IW'(i)))) begin
                    n_rank[i] = r_rank[i] + RW'(1);
                end
            end
            n_rank[w_slot]  = '0;
            n_valid[w_slot] = 1'b1;
            if (!w_evict) begin
                n_count = r_count + CW'(1);
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd  <= t_cmd'(i_command);
            r_key  <= i_key;
            r_wval <= i_write_value;
        end
    end

    // Control state. A capacity write empties the store; the user must write it only while idle (not enforced here).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rank  <= '0;
            r_count <= '0;
            r_cap   <= LKVC_CAP_RESET;
        end else if (i_cfg_we) begin
            r_valid <= '0;
            r_rank  <= '0;
            r_count <= '0;
            r_cap   <= i_cfg_data;
        end else if (w_fire) begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
            r_count <= n_count;
        end
    end

    // Entry payload: a put that hits overwrites the value, an insert writes key and value.
    always_ff @(posedge i_clk) begin
        if (w_fire && w_hit && (r_cmd == CMD_PUT)) begin
            r_vals[w_hit_idx] <= r_wval;
        end else if (w_fire && w_insert) begin
            r_keys[w_slot] <= w_key;
            r_vals[w_slot] <= r_wval;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_hit   <= w_hit;
            r_rval  <= (w_hit && (r_cmd == CMD_GET)) ? r_vals[w_hit_idx] : '0;
            r_ev    <= w_evict;
            r_evkey <= w_evict ? LKVC_KEY_W'(r_keys[w_slot]) : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_read_value  = r_rval;
    assign o_evicted     = r_ev;
    assign o_evicted_key = r_evkey;

    // The occupancy count always equals the number of valid entries.
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("occupancy count differs from the number of valid entries");

    // The store never holds more entries than the effective capacity.
    a_count_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_count) <= w_eff_cap)
        else $error("occupancy exceeds the effective capacity");

    // An eviction only happens on a miss.
    a_evict_not_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_hit && r_ev))
        else $error("result reports both a hit and an eviction");

    // A stalled stage leaves the entry state untouched.
    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_fire && !i_cfg_we) |=> ($stable(r_count) && $stable(r_valid)))
        else $error("entry state changed while the stage was stalled");

endmodule

>>> hdl/lkvc_lookup.sv
// Fully associative key match across all valid entries with first-match priority.
module lkvc_lookup #(
    parameter int DEPTH    = lkvc_pkg::LKVC_DEPTH,
    parameter int KEY_BITS = lkvc_pkg::LKVC_KEY_BITS,
    parameter int IW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic [DEPTH-1:0][KEY_BITS-1:0] i_keys,
    input  logic [DEPTH-1:0]               i_valid,
    input  logic [KEY_BITS-1:0]            i_key,
    output logic                           o_hit,
    output logic [IW-1:0]                  o_index
);

    logic [DEPTH-1:0] w_match;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_match[i] = i_valid[i] && (i_keys[i] == i_key);
        end
    end

    // Scan from the top so that the lowest matching slot wins.
    always_comb begin
        o_hit   = 1'b0;
        o_index = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                o_hit   = 1'b1;
                o_index = IW'(i);
            end
        end
    end

endmodule

>>> hdl/lkvc_victim.sv
// Slot selection for an insert: the least recent entry when full, else the first free slot.
module lkvc_victim #(
    parameter int DEPTH = lkvc_pkg::LKVC_DEPTH,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int RW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic [DEPTH-1:0]         i_valid,
    input  logic [DEPTH-1:0][RW-1:0] i_rank,
    input  logic [RW-1:0]            i_oldest,
    input  logic                     i_full,
    output logic                     o_evict,
    output logic                     o_slot_ok,
    output logic [IW-1:0]            o_slot
);

    logic            w_old_found;
    logic [IW-1:0]   w_old_idx;
    logic            w_free_found;
    logic [IW-1:0]   w_free_idx;

    always_comb begin
        w_old_found  = 1'b0;
        w_old_idx    = '0;
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (i_valid[i] && (i_rank[i] == i_oldest)) begin
                w_old_found = 1'b1;
                w_old_idx   = IW'(i);
            end
            if (!i_valid[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = IW'(i);
            end
        end
    end

    // When the store is full but no entry carries the oldest rank, fall back to a free slot.
    assign o_evict   = i_full && w_old_found;
    assign o_slot_ok = o_evict || w_free_found;
    assign o_slot    = o_evict ? w_old_idx : w_free_idx;

endmodule
